// ----- rtl/round_robin_read_cache_assert.svh -----
// Assertion macros used by the cache top level.
`ifndef ROUND_ROBIN_READ_CACHE_ASSERT_SVH
`define ROUND_ROBIN_READ_CACHE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RRC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cache check failed");

// Check cons in the cycle after ante.
`define RRC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cache check failed");

`endif

// ----- rtl/rrc_pkg.sv -----
// Shared types and codes of the round-robin read cache.
`timescale 1ns / 1ps
package rrc_pkg;

    localparam int SIZE_W = 6;

    localparam logic REQ_READ = 1'b0;
    localparam logic REQ_FILL = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FILL = 2'd1,
        KIND_BUSY = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOKUP = 6'b000010,
        ST_MATCH  = 6'b000100,
        ST_RD     = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_REJ    = 6'b100000
    } state_t;

    // Commands from the controller to the tag store.
    typedef struct packed {
        logic lookup;     // register the match vector for the query line
        logic retag;      // claim the victim line for the query line
        logic fill_done;  // mark the filled line valid
    } tag_cmd_t;

endpackage

// ----- rtl/rrc_tag_store.sv -----
// Tag store: tags, valid bits, registered match vector, round-robin victim pointer.
`timescale 1ns / 1ps
module rrc_tag_store import rrc_pkg::*; #(
    parameter int LINE_COUNT = 16,
    parameter int LINE_W = 27,
    localparam int SLOT_W = $clog2(LINE_COUNT)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tag_cmd_t          cmd,
    input  logic [LINE_W-1:0] query_line,
    input  logic [SLOT_W-1:0] done_slot,
    output logic              hit,
    output logic [SLOT_W-1:0] hit_slot,
    output logic [SLOT_W-1:0] victim_slot
);

    logic [LINE_W-1:0]     tag_reg [LINE_COUNT];
    logic [LINE_COUNT-1:0] valid_reg;
    logic [LINE_COUNT-1:0] match_reg;
    logic [SLOT_W-1:0]     victim_reg;

    assign victim_slot = victim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            victim_reg <= '0;
        end else begin
            if (cmd.retag) begin
                valid_reg[victim_reg] <= 1'b0;
                if (victim_reg == SLOT_W'(LINE_COUNT - 1)) begin
                    victim_reg <= '0;
                end else begin
                    victim_reg <= victim_reg + 1'b1;
                end
            end
            if (cmd.fill_done) begin
                valid_reg[done_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.retag) begin
            tag_reg[victim_reg] <= query_line;
        end
        if (cmd.lookup) begin
            for (int i = 0; i < LINE_COUNT; i++) begin
                match_reg[i] <= valid_reg[i] && (tag_reg[i] == query_line);
            end
        end
    end

    // Lowest matching line wins.
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

endmodule

// ----- rtl/rrc_data_ram.sv -----
// Line data memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rrc_data_ram #(
    parameter int DEPTH = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/round_robin_read_cache.sv -----
// Top level of the round-robin read cache.
`timescale 1ns / 1ps
// Read-only, fully associative cache of LINE_COUNT lines of LINE_BYTES bytes.
// A read item (type 0) names an address and a size of 1 to LINE_BYTES bytes
// (larger sizes saturate, size zero is dropped); a read that crosses a line
// boundary is looked up as two parts. A hit returns the bytes one item per
// cycle while the output is not stalled, in address order; a miss retags the
// round-robin victim line and returns one fill-request item carrying the line
// number. The block then expects LINE_BYTES fill-byte items (type 1), stores
// them, and returns the waiting bytes followed by the lookup of any deferred
// second part. A read that arrives during a fill gets one busy item back; a
// fill byte that arrives with no fill open is dropped. The final item caused
// by an input carries m_last. A part is looked up through accept, registered
// tag compare and hit select, then the data memory read is primed, after
// which bytes leave at one per cycle while the output is not stalled, set by
// the single read port of the data memory. A new item is taken only once the
// previous one has finished its work, though its last result may still sit
// in the output register. No clearing pass is needed after reset.
module round_robin_read_cache import rrc_pkg::*; #(
    parameter int LINE_BYTES = 32,
    parameter int LINE_COUNT = 16,
    parameter int ADDR_BITS  = 32,
    localparam int OFF_W  = $clog2(LINE_BYTES),
    localparam int LINE_W = ADDR_BITS - OFF_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [ADDR_BITS-1:0] s_address,
    input  logic [SIZE_W-1:0]    s_size,
    input  logic [7:0]           s_fill_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_data_byte,
    output logic [LINE_W-1:0]    m_fill_line,
    output logic                 m_last
);

`include "round_robin_read_cache_assert.svh"

    localparam int SLOT_W = $clog2(LINE_COUNT);
    localparam int CNT_W  = $clog2(LINE_BYTES + 1);
    localparam int SZ_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int RAM_DEPTH = LINE_COUNT * LINE_BYTES;
    localparam int RAM_AW    = SLOT_W + OFF_W;

    // Control state
    state_t            state_reg, state_next;
    logic              busy_reg, busy_next;
    logic [OFF_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic              sec_valid_reg, sec_valid_next;
    logic              m_valid_reg, m_valid_next;

    // Payload state
    logic [LINE_W-1:0] cur_line_reg, cur_line_next;
    logic [OFF_W-1:0]  cur_off_reg, cur_off_next;
    logic [LINE_W-1:0] sec_line_reg, sec_line_next;
    logic [CNT_W-1:0]  sec_cnt_reg, sec_cnt_next;
    kind_t             kind_reg, kind_next;
    logic [7:0]        data_reg, data_next;
    logic [LINE_W-1:0] fline_reg, fline_next;
    logic              last_reg, last_next;

    logic              in_accept;
    logic              out_free;
    tag_cmd_t          tag_cmd;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] victim_slot;
    logic              fill_wr;
    logic              fill_last;
    logic              rd_en;
    logic [OFF_W-1:0]  rd_off;
    logic [7:0]        rd_data;

    // Split of an incoming read
    logic [OFF_W-1:0]  req_off;
    logic [LINE_W-1:0] req_line;
    logic [SZ_W-1:0]   size_ext;
    logic [CNT_W-1:0]  size_sat;
    logic [CNT_W-1:0]  room;
    logic [CNT_W-1:0]  part1;
    logic [CNT_W-1:0]  part2;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_kind      = kind_reg;
    assign m_data_byte = data_reg;
    assign m_fill_line = fline_reg;
    assign m_last      = last_reg;

    assign req_off  = s_address[OFF_W-1:0];
    assign req_line = s_address[ADDR_BITS-1:OFF_W];
    assign size_ext = SZ_W'(s_size);
    assign size_sat = (size_ext > SZ_W'(LINE_BYTES)) ? CNT_W'(LINE_BYTES)
                                                     : CNT_W'(size_ext);
    assign room     = CNT_W'(LINE_BYTES) - CNT_W'(req_off);
    assign part1    = (room > size_sat) ? size_sat : room;
    assign part2    = size_sat - part1;

    // Fill bytes land in the line under fill, in address order.
    assign fill_wr   = in_accept && (s_req_type == REQ_FILL) && busy_reg;
    assign fill_last = fill_wr && (fill_cnt_reg == OFF_W'(LINE_BYTES - 1));

    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        fill_cnt_next  = fill_cnt_reg;
        slot_next      = slot_reg;
        cur_cnt_next   = cur_cnt_reg;
        sec_valid_next = sec_valid_reg;
        cur_line_next  = cur_line_reg;
        cur_off_next   = cur_off_reg;
        sec_line_next  = sec_line_reg;
        sec_cnt_next   = sec_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        fline_next     = fline_reg;
        last_next      = last_reg;
        tag_cmd        = '0;
        rd_en          = 1'b0;
        rd_off         = cur_off_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_req_type == REQ_READ) begin
                        if (busy_reg) begin
                            state_next = ST_REJ;
                        end else if (s_size != '0) begin
                            // Hold the first part in cur, the second in sec.
                            cur_line_next  = req_line;
                            cur_off_next   = req_off;
                            cur_cnt_next   = part1;
                            sec_valid_next = (part2 != '0);
                            sec_line_next  = req_line + 1'b1;
                            sec_cnt_next   = part2;
                            state_next     = ST_LOOKUP;
                        end
                    end else if (busy_reg) begin
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                        if (fill_last) begin
                            // Line complete: send the waiting bytes.
                            tag_cmd.fill_done = 1'b1;
                            busy_next         = 1'b0;
                            state_next        = ST_RD;
                        end
                    end
                end
            end
            ST_LOOKUP: begin
                tag_cmd.lookup = 1'b1;
                state_next     = ST_MATCH;
            end
            ST_MATCH: begin
                if (hit) begin
                    slot_next  = hit_slot;
                    state_next = ST_RD;
                end else if (out_free) begin
                    // Miss: claim the victim, ask for the line, wait for fill.
                    tag_cmd.retag = 1'b1;
                    slot_next     = victim_slot;
                    busy_next     = 1'b1;
                    fill_cnt_next = '0;
                    m_valid_next  = 1'b1;
                    kind_next     = KIND_FILL;
                    data_next     = '0;
                    fline_next    = cur_line_reg;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_DATA;
                    data_next    = rd_data;
                    fline_next   = '0;
                    last_next    = (cur_cnt_reg == CNT_W'(1)) && !sec_valid_reg;
                    if (cur_cnt_reg == CNT_W'(1)) begin
                        if (sec_valid_reg) begin
                            cur_line_next  = sec_line_reg;
                            cur_off_next   = '0;
                            cur_cnt_next   = sec_cnt_reg;
                            sec_valid_next = 1'b0;
                            state_next     = ST_LOOKUP;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        // Fetch the next byte while this one goes out.
                        cur_cnt_next = cur_cnt_reg - 1'b1;
                        cur_off_next = cur_off_reg + 1'b1;
                        rd_off       = cur_off_reg + 1'b1;
                        rd_en        = 1'b1;
                    end
                end
            end
            ST_REJ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_BUSY;
                    data_next    = '0;
                    fline_next   = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
            slot_reg      <= '0;
            cur_cnt_reg   <= '0;
            sec_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            fill_cnt_reg  <= fill_cnt_next;
            slot_reg      <= slot_next;
            cur_cnt_reg   <= cur_cnt_next;
            sec_valid_reg <= sec_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_line_reg <= cur_line_next;
        cur_off_reg  <= cur_off_next;
        sec_line_reg <= sec_line_next;
        sec_cnt_reg  <= sec_cnt_next;
        kind_reg     <= kind_next;
        data_reg     <= data_next;
        fline_reg    <= fline_next;
        last_reg     <= last_next;
    end

    rrc_tag_store #(
        .LINE_COUNT (LINE_COUNT),
        .LINE_W     (LINE_W)
    ) u_tags (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (tag_cmd),
        .query_line  (cur_line_reg),
        .done_slot   (slot_reg),
        .hit         (hit),
        .hit_slot    (hit_slot),
        .victim_slot (victim_slot)
    );

    rrc_data_ram #(
        .DEPTH (RAM_DEPTH)
    ) u_data (
        .aclk    (aclk),
        .wr_en   (fill_wr),
        .wr_addr ({slot_reg, fill_cnt_reg}),
        .wr_data (s_fill_byte),
        .rd_en   (rd_en),
        .rd_addr (RAM_AW'({slot_reg, rd_off})),
        .rd_data (rd_data)
    );

    // A fill starts together with its fill request in the output register.
    `RRC_ASSERT_IMP(a_fill_req_on_start, aclk, aresetn, $rose(busy_reg),
        m_valid_reg && (kind_reg == KIND_FILL) && last_reg)
    // A completed fill goes straight to reading the waiting bytes.
    `RRC_ASSERT_IMP(a_fill_done_reads, aclk, aresetn, $fell(busy_reg),
        state_reg == ST_RD)
    // Bytes are emitted only while some remain in the part.
    `RRC_ASSERT_IMP(a_emit_has_bytes, aclk, aresetn, state_reg == ST_EMIT,
        cur_cnt_reg != '0)

endmodule
